// File: hw/rtl/wpd_pkg.sv
// Shared constants and types for the window plateau detector.
// No dependencies; imported by wpd_divider and window_plateau_detector.
`default_nettype none

package wpd_pkg;

  localparam int HISTORY_DEPTH = 64;
  localparam int DATA_W        = 32;
  localparam int ITER_W        = 31;
  localparam int WLEN_W        = 7;
  localparam int ADDR_W        = $clog2(HISTORY_DEPTH);
  localparam int WIN_W         = $clog2(HISTORY_DEPTH + 1);
  // sum of up to HISTORY_DEPTH signed 32-bit samples
  localparam int SUM_W         = DATA_W + $clog2(HISTORY_DEPTH);
  localparam int DIV_CNT_W     = $clog2(SUM_W + 1);
  localparam int DEV_W         = DATA_W + 1;
  localparam int PROD_W        = 2 * DATA_W;

  localparam logic [DATA_W-1:0] REL_THR_RESET = 32'd655;
  localparam logic [WLEN_W-1:0] WIN_LEN_RESET = 7'd16;

  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REL_THRESHOLD = 1'b0,
    REG_WINDOW_LEN    = 1'b1
  } cfg_reg_e;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

endpackage

`default_nettype wire

// File: hw/rtl/wpd_divider.sv
// Restoring unsigned divider: window sum magnitude by window length, one bit per cycle.
// Depends on wpd_pkg.
`default_nettype none

module wpd_divider (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [wpd_pkg::SUM_W-1:0]  dividend_i,
  input  wire logic [wpd_pkg::WIN_W-1:0]  divisor_i,
  output logic                            done_o,
  output logic [wpd_pkg::SUM_W-1:0]       quotient_o
);
  import wpd_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [WIN_W-1:0]     rem_q, rem_d;
  logic [SUM_W-1:0]     quo_q, quo_d;
  logic [WIN_W-1:0]     div_q, div_d;
  logic [WIN_W:0]       trial;
  logic                 take;

  // dividend bits shift out of quo_q's top while quotient bits enter its bottom
  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign take  = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = take ? WIN_W'(trial - {1'b0, div_q}) : trial[WIN_W-1:0];
      quo_d = {quo_q[SUM_W-2:0], take};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(SUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// File: hw/rtl/window_plateau_detector.sv
// Window plateau detector: top level with sample history RAM, window sum/deviation
// passes and threshold check. Depends on wpd_pkg and wpd_divider.
// A clear, or a sample that triggers no evaluation, goes straight to the output
// register; an evaluated sample first makes two sequential passes over the history
// RAM (sum, then deviation) with the bit-serial divider between them. New requests
// are stalled until the result is loaded into the output register, where it sits
// until taken.
// Reset: async active low; history empty, no latch, level 0, onset -1, threshold 655,
// window 16. RAM contents are not cleared; only entries written since are ever read.
`default_nettype none

module window_plateau_detector (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // config writes
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [wpd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [wpd_pkg::DATA_W-1:0]    cfg_data_i,
  // request channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          kind_i,
  input  wire logic signed [wpd_pkg::DATA_W-1:0] sample_i,
  input  wire logic [wpd_pkg::ITER_W-1:0]    iteration_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               detected_o,
  output logic signed [wpd_pkg::DATA_W-1:0]  level_o,
  output logic signed [wpd_pkg::DATA_W-1:0]  onset_o
);
  import wpd_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SUM  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_DEV  = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_CMP  = 3'd5;
  localparam logic [2:0] ST_EMIT = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [ADDR_W-1:0] slot_q, slot_d;
  logic [WIN_W-1:0]  fill_q, fill_d;
  logic              latched_q, latched_d;
  logic [DATA_W-1:0] held_level_q, held_level_d;
  logic [DATA_W-1:0] held_onset_q, held_onset_d;
  logic [DATA_W-1:0] thr_q;
  logic [WLEN_W-1:0] wlen_q;
  logic              out_valid_q, out_valid_d;
  logic [ADDR_W-1:0] rd_addr_q, rd_addr_d;
  logic [WIN_W-1:0]  idx_q, idx_d;
  logic              rvalid_q, rvalid_d;

  logic [WIN_W-1:0]  win_q, win_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic [ADDR_W-1:0] start_q, start_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [DATA_W-1:0] mean_q, mean_d;
  logic [DEV_W-1:0]  maxdev_q, maxdev_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic              det_q, det_d;
  logic              out_det_q;
  logic [DATA_W-1:0] out_level_q, out_onset_q;

  logic [DATA_W-1:0] mem_q [HISTORY_DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic              mem_we;

  logic              accept;
  logic              out_load;
  logic [WIN_W-1:0]  win_eff;
  logic [ADDR_W-1:0] slot_inc;
  logic [WIN_W-1:0]  fill_next;
  logic [ADDR_W:0]   start_raw;
  logic [ADDR_W-1:0] start_calc;
  logic [ADDR_W-1:0] rd_addr_inc;
  logic              issue;
  logic              sum_neg;
  logic [SUM_W-1:0]  div_dividend;
  logic              div_start;
  logic              div_done;
  logic [SUM_W-1:0]  div_quo;
  logic [SUM_W-1:0]  quo_signed;
  logic [DEV_W-1:0]  dev_diff;
  logic [DEV_W-1:0]  dev_abs;
  logic              mean_pos;
  logic              hit;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = state_q != ST_IDLE;
  assign accept      = in_valid_i && !in_stall_o;

  // window length clamped into 1..HISTORY_DEPTH
  always_comb begin
    if (wlen_q == '0) begin
      win_eff = WIN_W'(1);
    end else if (32'(wlen_q) > 32'(HISTORY_DEPTH)) begin
      win_eff = WIN_W'(HISTORY_DEPTH);
    end else begin
      win_eff = WIN_W'(wlen_q);
    end
  end

  assign slot_inc    = (slot_q == ADDR_W'(HISTORY_DEPTH - 1)) ? '0 : slot_q + 1'b1;
  assign fill_next   = (fill_q == WIN_W'(HISTORY_DEPTH)) ? fill_q : fill_q + 1'b1;
  assign start_raw   = (ADDR_W+1)'(slot_inc) + (ADDR_W+1)'(HISTORY_DEPTH)
                       - (ADDR_W+1)'(win_eff);
  assign start_calc  = (start_raw >= (ADDR_W+1)'(HISTORY_DEPTH))
                       ? ADDR_W'(start_raw - (ADDR_W+1)'(HISTORY_DEPTH))
                       : start_raw[ADDR_W-1:0];
  assign rd_addr_inc = (rd_addr_q == ADDR_W'(HISTORY_DEPTH - 1)) ? '0 : rd_addr_q + 1'b1;
  assign issue       = idx_q != win_q;

  assign sum_neg      = sum_q[SUM_W-1];
  assign div_dividend = sum_neg ? -sum_q : sum_q;
  assign quo_signed   = sum_neg ? -div_quo : div_quo;

  assign dev_diff = {rdata_q[DATA_W-1], rdata_q} - {mean_q[DATA_W-1], mean_q};
  assign dev_abs  = dev_diff[DEV_W-1] ? -dev_diff : dev_diff;

  assign mean_pos = !mean_q[DATA_W-1] && (mean_q != '0);
  assign hit      = mean_pos ? ({15'b0, maxdev_q, 16'b0} < prod_q)
                             : ({1'b0, thr_q} > maxdev_q);

  wpd_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (win_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d      = state_q;
    slot_d       = slot_q;
    fill_d       = fill_q;
    latched_d    = latched_q;
    held_level_d = held_level_q;
    held_onset_d = held_onset_q;
    rd_addr_d    = rd_addr_q;
    idx_d        = idx_q;
    rvalid_d     = 1'b0;
    win_d        = win_q;
    iter_d       = iter_q;
    start_d      = start_q;
    sum_d        = sum_q;
    mean_d       = mean_q;
    maxdev_d     = maxdev_q;
    prod_d       = prod_q;
    det_d        = det_q;
    mem_we       = 1'b0;
    div_start    = 1'b0;
    out_load     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (kind_i == KIND_CLEAR) begin
            slot_d       = '0;
            fill_d       = '0;
            latched_d    = 1'b0;
            held_level_d = '0;
            held_onset_d = '1;
            det_d        = 1'b0;
            state_d      = ST_EMIT;
          end else begin
            mem_we    = 1'b1;
            slot_d    = slot_inc;
            fill_d    = fill_next;
            win_d     = win_eff;
            iter_d    = iteration_i;
            start_d   = start_calc;
            rd_addr_d = start_calc;
            idx_d     = '0;
            sum_d     = '0;
            if (fill_next >= win_eff && !latched_q) begin
              state_d = ST_SUM;
            end else begin
              det_d   = (fill_next >= win_eff) && latched_q;
              state_d = ST_EMIT;
            end
          end
        end
      end
      ST_SUM: begin
        if (issue) begin
          rvalid_d  = 1'b1;
          idx_d     = idx_q + 1'b1;
          rd_addr_d = rd_addr_inc;
        end
        if (rvalid_q) begin
          sum_d = sum_q + {{(SUM_W-DATA_W){rdata_q[DATA_W-1]}}, rdata_q};
        end
        if (!issue && !rvalid_q) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          mean_d    = quo_signed[DATA_W-1:0];
          rd_addr_d = start_q;
          idx_d     = '0;
          maxdev_d  = '0;
          state_d   = ST_DEV;
        end
      end
      ST_DEV: begin
        if (issue) begin
          rvalid_d  = 1'b1;
          idx_d     = idx_q + 1'b1;
          rd_addr_d = rd_addr_inc;
        end
        if (rvalid_q && dev_abs > maxdev_q) begin
          maxdev_d = dev_abs;
        end
        if (!issue && !rvalid_q) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d  = PROD_W'(thr_q) * PROD_W'(mean_q);
        state_d = ST_CMP;
      end
      ST_CMP: begin
        det_d = hit;
        if (hit) begin
          latched_d    = 1'b1;
          held_level_d = mean_q;
          held_onset_d = {1'b0, iter_q} - DATA_W'(win_q >> 1);
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      slot_q       <= '0;
      fill_q       <= '0;
      latched_q    <= 1'b0;
      held_level_q <= '0;
      held_onset_q <= '1;
      out_valid_q  <= 1'b0;
      rd_addr_q    <= '0;
      idx_q        <= '0;
      rvalid_q     <= 1'b0;
      win_q        <= WIN_W'(1);
      thr_q        <= REL_THR_RESET;
      wlen_q       <= WIN_LEN_RESET;
    end else begin
      state_q      <= state_d;
      slot_q       <= slot_d;
      fill_q       <= fill_d;
      latched_q    <= latched_d;
      held_level_q <= held_level_d;
      held_onset_q <= held_onset_d;
      out_valid_q  <= out_valid_d;
      rd_addr_q    <= rd_addr_d;
      idx_q        <= idx_d;
      rvalid_q     <= rvalid_d;
      win_q        <= win_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_REL_THRESHOLD: thr_q  <= cfg_data_i;
          REG_WINDOW_LEN:    wlen_q <= cfg_data_i[WLEN_W-1:0];
          default:           ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    iter_q   <= iter_d;
    start_q  <= start_d;
    sum_q    <= sum_d;
    mean_q   <= mean_d;
    maxdev_q <= maxdev_d;
    prod_q   <= prod_d;
    det_q    <= det_d;
    if (out_load) begin
      out_det_q   <= det_q;
      out_level_q <= held_level_q;
      out_onset_q <= held_onset_q;
    end
  end

  // history RAM, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[slot_q] <= sample_i;
    end
    rdata_q <= mem_q[rd_addr_q];
  end

  assign out_valid_o = out_valid_q;
  assign detected_o  = out_det_q;
  assign level_o     = out_level_q;
  assign onset_o     = out_onset_q;

`ifndef SYNTH
  a_fill_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= 32'(HISTORY_DEPTH))
    else $error("fill count above history depth");

  a_slot_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(slot_q) < 32'(HISTORY_DEPTH))
    else $error("write slot out of range");

  a_div_in_div_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside divide phase");

  a_clear_resets : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && kind_i == KIND_CLEAR) |=> (!latched_q && fill_q == '0 && slot_q == '0))
    else $error("clear did not reset detector state");

  a_eval_needs_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM) |-> (fill_q >= win_q && !latched_q))
    else $error("evaluation started without a full window or while latched");
`endif

endmodule

`default_nettype wire
